FILE: sv/frame_decoder_sum_checksum_defines.svh
// Assertion macros shared by the frame checker RTL.
// No dependencies; included by the top level of the frame checker.
`ifndef FRAME_DECODER_SUM_CHECKSUM_DEFINES_SVH
`define FRAME_DECODER_SUM_CHECKSUM_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define FDSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("frame checker assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define FDSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("frame checker assertion failed");

`endif

FILE: sv/fdsc_pkg.sv
// Types and constants of the frame checker.
// No dependencies; used by every module of the frame checker.
package fdsc_pkg;

	localparam logic [7:0] HDR0 = 8'hEE;
	localparam logic [7:0] HDR1 = 8'h16;
	localparam logic [9:0] MIN_FRAME = 10'd6;
	localparam logic [9:0] FRAME_OVERHEAD = 10'd5;
	localparam logic [8:0] INDEX_MAX = 9'd511;
	localparam logic [8:0] IDX_ID = 9'd2;
	localparam logic [8:0] IDX_LENGTH = 9'd3;
	localparam logic [8:0] IDX_COMMAND = 9'd4;
	localparam logic [8:0] IDX_PAYLOAD = 9'd5;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_SHORT = 3'd1,
		ST_HEADER = 3'd2,
		ST_LENGTH = 3'd3,
		ST_CHECKSUM = 3'd4
	} status_t;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_STATUS = 1'b1
	} item_kind_t;

	typedef struct packed {
		logic has_result;
		item_kind_t kind;
		logic [7:0] payload_byte;
		logic [7:0] frame_id;
		logic [7:0] command;
		logic [7:0] payload_length;
		status_t status;
	} result_t;

endpackage

FILE: sv/fdsc_track.sv
// Frame tracking state and result logic of the frame checker.
// Depends on fdsc_pkg.
module fdsc_track (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic [7:0]       rx_byte_s1,
	input  logic             end_of_buffer_s1,
	output fdsc_pkg::result_t res
);
	import fdsc_pkg::*;

	logic [8:0] byte_index_q;
	logic       header_good_q;
	logic [7:0] held_id_q;
	logic [7:0] held_length_q;
	logic [7:0] held_command_q;
	logic [7:0] running_sum_q;
	logic [9:0] total;
	logic       length_ok;

	assign total = {1'b0, byte_index_q} + 10'd1;
	assign length_ok = (total == ({2'b00, held_length_q} + FRAME_OVERHEAD)) &&
		(held_length_q != 8'd0);

	always_comb begin
		res = '0;
		res.kind = KIND_PAYLOAD;
		res.status = ST_OK;
		if (end_of_buffer_s1) begin
			res.has_result = 1'b1;
			res.kind = KIND_STATUS;
			if (total < MIN_FRAME) begin
				res.status = ST_SHORT;
			end else if (!header_good_q) begin
				res.status = ST_HEADER;
			end else if (!length_ok) begin
				res.status = ST_LENGTH;
			end else if (running_sum_q != rx_byte_s1) begin
				res.status = ST_CHECKSUM;
			end else begin
				res.status = ST_OK;
			end
			if (res.status != ST_SHORT) begin
				res.frame_id = held_id_q;
				res.command = held_command_q;
			end
			if (res.status == ST_OK) begin
				res.payload_length = held_length_q - 8'd1;
			end
		end else if (byte_index_q >= IDX_PAYLOAD) begin
			res.has_result = 1'b1;
			res.payload_byte = rx_byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q <= '0;
			header_good_q <= 1'b1;
			held_id_q <= '0;
			held_length_q <= '0;
			held_command_q <= '0;
			running_sum_q <= '0;
		end else if (advance) begin
			if (end_of_buffer_s1) begin
				// The last byte closes the frame and returns all state to reset.
				byte_index_q <= '0;
				header_good_q <= 1'b1;
				held_id_q <= '0;
				held_length_q <= '0;
				held_command_q <= '0;
				running_sum_q <= '0;
			end else begin
				if (byte_index_q == 9'd0) begin
					header_good_q <= (rx_byte_s1 == HDR0);
				end else if (byte_index_q == 9'd1) begin
					header_good_q <= header_good_q && (rx_byte_s1 == HDR1);
				end else if (byte_index_q == IDX_ID) begin
					held_id_q <= rx_byte_s1;
				end else if (byte_index_q == IDX_LENGTH) begin
					held_length_q <= rx_byte_s1;
				end else if (byte_index_q == IDX_COMMAND) begin
					held_command_q <= rx_byte_s1;
				end
				if (byte_index_q >= IDX_ID) begin
					running_sum_q <= running_sum_q + rx_byte_s1;
				end
				if (byte_index_q != INDEX_MAX) begin
					byte_index_q <= byte_index_q + 9'd1;
				end
			end
		end
	end

endmodule

FILE: sv/fdsc_out_reg.sv
// Result register of the frame checker, holding one result for the consumer.
// Depends on fdsc_pkg.
module fdsc_out_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  fdsc_pkg::result_t    res,
	input  logic                 result_stall,
	output logic                 result_valid,
	output fdsc_pkg::item_kind_t item_kind,
	output logic [7:0]           payload_byte,
	output logic [7:0]           frame_id,
	output logic [7:0]           command,
	output logic [7:0]           payload_length,
	output fdsc_pkg::status_t    status
);
	import fdsc_pkg::*;

	logic    valid_q;
	result_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res;
		end
	end

	assign result_valid = valid_q;
	assign item_kind = data_q.kind;
	assign payload_byte = data_q.payload_byte;
	assign frame_id = data_q.frame_id;
	assign command = data_q.command;
	assign payload_length = data_q.payload_length;
	assign status = data_q.status;

endmodule

FILE: sv/frame_decoder_sum_checksum.sv
// Top level of the byte-serial frame checker with byte-sum checksum.
// Depends on fdsc_pkg, fdsc_track, fdsc_out_reg and the assertion header.
//
//   channel   valid / stall               payload
//   byte      byte_valid / byte_stall     rx_byte, end_of_buffer
//   result    result_valid / result_stall item_kind, payload_byte, frame_id,
//                                         command, payload_length, status
//
// One byte request is taken every cycle unless stalled; an accepted byte sits in the
// input register, and its result enters the result register at the next edge when that
// register is free. The running sum and byte counter update per byte, so a new byte can
// follow directly. Reset clears the valid flags and the frame state; no clearing pass. A
// stalled result holds in the result register; byte_stall rises only when the result
// register is full, stalled, and the byte in the input register has a result.
`include "frame_decoder_sum_checksum_defines.svh"

module frame_decoder_sum_checksum (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_stall,
	input  logic [7:0]           rx_byte,
	input  logic                 end_of_buffer,
	output logic                 result_valid,
	input  logic                 result_stall,
	output fdsc_pkg::item_kind_t item_kind,
	output logic [7:0]           payload_byte,
	output logic [7:0]           frame_id,
	output logic [7:0]           command,
	output logic [7:0]           payload_length,
	output fdsc_pkg::status_t    status
);
	import fdsc_pkg::*;

	// Input register: holds the byte request being evaluated.
	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	logic       end_of_buffer_s1;
	logic       accept;
	logic       advance;
	result_t    res;

	// The byte in the input register moves on when it produces no result, or
	// when the result register is empty or being emptied in this cycle.
	assign advance = valid_s1 && (!res.has_result || !result_valid || !result_stall);
	assign byte_stall = valid_s1 && !advance;
	assign accept = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rx_byte_s1 <= rx_byte;
			end_of_buffer_s1 <= end_of_buffer;
		end
	end

	// Frame state and the result that the current byte causes.
	fdsc_track u_track (
		.clk              (clk),
		.arst_n           (arst_n),
		.advance          (advance),
		.rx_byte_s1       (rx_byte_s1),
		.end_of_buffer_s1 (end_of_buffer_s1),
		.res              (res)
	);

	// Result register toward the consumer.
	fdsc_out_reg u_out_reg (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (advance && res.has_result),
		.res            (res),
		.result_stall   (result_stall),
		.result_valid   (result_valid),
		.item_kind      (item_kind),
		.payload_byte   (payload_byte),
		.frame_id       (frame_id),
		.command        (command),
		.payload_length (payload_length),
		.status         (status)
	);

	// Byte requests are held off only while a result waits in a full register.
	`FDSC_ASSERT_NOW(a_stall_needs_full_out, clk, arst_n, byte_stall, result_valid && result_stall)
	// A status result never carries a payload byte.
	`FDSC_ASSERT_NOW(a_status_no_payload, clk, arst_n, result_valid && item_kind == KIND_STATUS, payload_byte == 8'd0)
	// A too-short frame reports no id or command.
	`FDSC_ASSERT_NOW(a_short_no_fields, clk, arst_n, result_valid && status == ST_SHORT, frame_id == 8'd0 && command == 8'd0)
	// A byte that moves on leaves the input register empty unless a new one arrives.
	`FDSC_ASSERT_NEXT(a_drain_s1, clk, arst_n, advance && !accept, !valid_s1)

endmodule
